/* rtl/ealu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ealu_pkg
// Shared types and constants of the eight-bit ALU with status flags.
// ----------------------------------------------------------------------------
package ealu_pkg;

	localparam int unsigned DataW = 8;
	localparam int unsigned CmdW  = 5;

	typedef enum logic [CmdW-1:0] {
		CMD_ADD  = 5'd0,
		CMD_ADDC = 5'd1,
		CMD_SUBB = 5'd2,
		CMD_INC  = 5'd3,
		CMD_DEC  = 5'd4,
		CMD_OR   = 5'd5,
		CMD_AND  = 5'd6,
		CMD_XOR  = 5'd7,
		CMD_RR   = 5'd8,
		CMD_RRC  = 5'd9,
		CMD_RL   = 5'd10,
		CMD_RLC  = 5'd11,
		CMD_SWAP = 5'd12,
		CMD_DA   = 5'd13,
		CMD_MUL  = 5'd14,
		CMD_DIV  = 5'd15,
		CMD_CPL  = 5'd16,
		CMD_CLR  = 5'd17,
		CMD_CMP  = 5'd18,
		CMD_MOV  = 5'd19
	} cmd_t;

	// decimal adjust
	localparam logic [3:0]       BcdDigitMax = 4'd9;
	localparam logic [DataW-1:0] DaLoAdj     = 8'h06;
	localparam logic [DataW-1:0] DaHiAdj     = 8'h60;

	// result of one operation, before parity
	typedef struct packed {
		logic [DataW-1:0] acc;
		logic [DataW-1:0] b;
		logic             c;
		logic             ac;
		logic             ov;
	} res_t;

	// restoring divider state: partial remainder and quotient/dividend shift
	typedef struct packed {
		logic [DataW-1:0] rem;
		logic [DataW-1:0] quo;
	} div_t;

endpackage

/* rtl/ealu_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ealu_req_if
// Request channel: operation and operands, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ealu_req_if;
	logic       valid;
	logic       ready;
	logic [4:0] command;
	logic [7:0] acc_in;
	logic [7:0] operand;
	logic [7:0] b_in;
	logic       carry_in;
	logic       aux_in;
	logic       ovf_in;

	modport source (
		output valid, command, acc_in, operand, b_in, carry_in, aux_in, ovf_in,
		input  ready
	);
	modport sink (
		input  valid, command, acc_in, operand, b_in, carry_in, aux_in, ovf_in,
		output ready
	);
endinterface

/* rtl/ealu_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ealu_rsp_if
// Response channel: new accumulator, B and flags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ealu_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] acc_out;
	logic [7:0] b_out;
	logic       carry_out;
	logic       aux_out;
	logic       ovf_out;
	logic       parity_out;

	modport source (
		output valid, acc_out, b_out, carry_out, aux_out, ovf_out, parity_out,
		input  ready
	);
	modport sink (
		input  valid, acc_out, b_out, carry_out, aux_out, ovf_out, parity_out,
		output ready
	);
endinterface

/* rtl/ealu_div4.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ealu_div4
// Four steps of unsigned restoring division, one quotient bit per step.
// ----------------------------------------------------------------------------
module ealu_div4
	import ealu_pkg::*;
(
	input  logic [DataW-1:0] divisor,
	input  div_t             d_in,
	output div_t             d_out
);

	always_comb begin
		logic [DataW:0]   trial;
		logic [DataW-1:0] rem;
		logic [DataW-1:0] quo;
		rem = d_in.rem;
		quo = d_in.quo;
		for (int i = 0; i < 4; i++) begin
			trial = {rem, quo[DataW-1]};
			if (trial >= {1'b0, divisor}) begin
				trial = trial - {1'b0, divisor};
				quo   = {quo[DataW-2:0], 1'b1};
			end else begin
				quo   = {quo[DataW-2:0], 1'b0};
			end
			// remainder stays below divisor, top bit is zero here
			rem = trial[DataW-1:0];
		end
		d_out.rem = rem;
		d_out.quo = quo;
	end

endmodule

/* rtl/eight_bit_alu_with_psw_flags_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_alu_with_psw_flags_top
// Three-stage pipelined 8-bit ALU with carry, aux-carry, overflow and parity.
//
//   channel  dir  beat contents
//   req      in   command, acc_in, operand, b_in, carry_in, aux_in, ovf_in
//   rsp      out  acc_out, b_out, carry_out, aux_out, ovf_out, parity_out
//
// One beat can enter every cycle while no stage is blocked. Stage 1 runs the
// ALU ops, the multiplier and the upper four divide steps, stage 2 the lower
// four divide steps, stage 3 parity. arst_n clears the stage valid bits only.
// Each stage holds while the stage after it is full and blocked; empty stages
// keep filling, so req.ready stays high while a finished result waits on rsp
// as long as any bubble is left.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_psw_flags_top
	import ealu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	ealu_req_if.sink  req,
	ealu_rsp_if.source rsp
);

	// ---------------------------------------------------------------- flow
	logic v_s1, v_s2, v_s3;
	logic ready_s1, ready_s2, ready_s3;

	// a stage may load when it is empty or its content moves on
	assign ready_s3  = !v_s3 || rsp.ready;
	assign ready_s2  = !v_s2 || ready_s3;
	assign ready_s1  = !v_s1 || ready_s2;
	assign req.ready = ready_s1;

	// ------------------------------------------------------- stage 1 logic
	cmd_t             cmd;
	res_t             alu_res;
	div_t             div_hi;
	logic [2*DataW-1:0] prod;

	assign cmd  = cmd_t'(req.command);
	assign prod = req.acc_in * req.b_in;

	always_comb begin
		logic [DataW:0]   sum;
		logic [DataW:0]   rhs;
		logic [4:0]       nib;
		logic             cin;
		logic [DataW-1:0] a;
		logic [DataW-1:0] v;
		a   = req.acc_in;
		v   = req.operand;
		sum = '0;
		rhs = '0;
		nib = '0;
		cin = 1'b0;
		alu_res.acc = a;
		alu_res.b   = req.b_in;
		alu_res.c   = req.carry_in;
		alu_res.ac  = req.aux_in;
		alu_res.ov  = req.ovf_in;
		case (cmd)
			CMD_ADD, CMD_ADDC: begin
				cin = (cmd == CMD_ADDC) ? req.carry_in : 1'b0;
				sum = {1'b0, a} + {1'b0, v} + {{DataW{1'b0}}, cin};
				nib = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
				alu_res.acc = sum[DataW-1:0];
				alu_res.c   = sum[DataW];
				alu_res.ac  = nib[4];
				alu_res.ov  = ~(a[7] ^ v[7]) & (a[7] ^ sum[7]);
			end
			CMD_SUBB: begin
				rhs = {1'b0, v} + {{DataW{1'b0}}, req.carry_in};
				sum = {1'b0, a} - rhs;
				nib = {1'b0, v[3:0]} + {4'd0, req.carry_in};
				alu_res.acc = sum[DataW-1:0];
				alu_res.c   = ({1'b0, a} < rhs);
				alu_res.ac  = ({1'b0, a[3:0]} < nib);
				alu_res.ov  = (a[7] ^ v[7]) & (a[7] ^ sum[7]);
			end
			CMD_INC:  alu_res.acc = a + 8'd1;
			CMD_DEC:  alu_res.acc = a - 8'd1;
			CMD_OR:   alu_res.acc = a | v;
			CMD_AND:  alu_res.acc = a & v;
			CMD_XOR:  alu_res.acc = a ^ v;
			CMD_RR:   alu_res.acc = {a[0], a[7:1]};
			CMD_RRC: begin
				alu_res.acc = {req.carry_in, a[7:1]};
				alu_res.c   = a[0];
			end
			CMD_RL:   alu_res.acc = {a[6:0], a[7]};
			CMD_RLC: begin
				alu_res.acc = {a[6:0], req.carry_in};
				alu_res.c   = a[7];
			end
			CMD_SWAP: alu_res.acc = {a[3:0], a[7:4]};
			CMD_DA: begin
				// carry can only be set here, never cleared
				sum = {1'b0, a};
				if (a[3:0] > BcdDigitMax || req.aux_in) begin
					sum = sum + {1'b0, DaLoAdj};
					if (sum[DataW]) begin
						alu_res.c = 1'b1;
					end
					sum[DataW] = 1'b0;
				end
				if (sum[7:4] > BcdDigitMax || alu_res.c) begin
					sum = {1'b0, sum[DataW-1:0] + DaHiAdj};
					alu_res.c = 1'b1;
				end
				alu_res.acc = sum[DataW-1:0];
			end
			CMD_MUL: begin
				alu_res.acc = prod[DataW-1:0];
				alu_res.b   = prod[2*DataW-1:DataW];
				alu_res.c   = 1'b0;
				alu_res.ov  = |prod[2*DataW-1:DataW];
			end
			CMD_DIV: begin
				// finished in stage 2
				alu_res.c = 1'b0;
			end
			CMD_CPL:  alu_res.acc = ~a;
			CMD_CLR:  alu_res.acc = '0;
			CMD_CMP:  alu_res.c   = (a < v);
			CMD_MOV:  alu_res.acc = v;
			default: ;
		endcase
	end

	// upper quotient bits
	ealu_div4 u_div_hi (
		.divisor (req.b_in),
		.d_in    ('{rem: '0, quo: req.acc_in}),
		.d_out   (div_hi)
	);

	// ------------------------------------------------------------ stage 1
	res_t             res_s1;
	div_t             div_s1;
	logic [DataW-1:0] divisor_s1;
	logic             is_div_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && req.valid) begin
			res_s1     <= alu_res;
			div_s1     <= div_hi;
			divisor_s1 <= req.b_in;
			is_div_s1  <= (cmd == CMD_DIV);
		end
	end

	// ------------------------------------------------------- stage 2 logic
	div_t div_lo;
	res_t res_fin;

	ealu_div4 u_div_lo (
		.divisor (divisor_s1),
		.d_in    (div_s1),
		.d_out   (div_lo)
	);

	always_comb begin
		res_fin = res_s1;
		if (is_div_s1) begin
			if (divisor_s1 == '0) begin
				// divide by zero: zero quotient and remainder, overflow set
				res_fin.acc = '0;
				res_fin.b   = '0;
				res_fin.ov  = 1'b1;
			end else begin
				res_fin.acc = div_lo.quo;
				res_fin.b   = div_lo.rem;
				res_fin.ov  = 1'b0;
			end
		end
	end

	// ------------------------------------------------------------ stage 2
	res_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			res_s2 <= res_fin;
		end
	end

	// ------------------------------------------- stage 3 (output register)
	res_t res_s3;
	logic par_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ready_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && v_s2) begin
			res_s3 <= res_s2;
			par_s3 <= ^res_s2.acc;
		end
	end

	assign rsp.valid      = v_s3;
	assign rsp.acc_out    = res_s3.acc;
	assign rsp.b_out      = res_s3.b;
	assign rsp.carry_out  = res_s3.c;
	assign rsp.aux_out    = res_s3.ac;
	assign rsp.ovf_out    = res_s3.ov;
	assign rsp.parity_out = par_s3;

	// ---------------------------------------------------------- assertions
`ifndef SYNTHESIS
	// a full stage that cannot move keeps its beat
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !ready_s3 |=> v_s2 && $stable(res_s2))
		else $error("stage 2 lost or changed a stalled beat");

	// divide by zero reaches stage 2 as zero quotient/remainder with overflow
	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ready_s2 && v_s1 && is_div_s1 && divisor_s1 == '0
		|=> res_s2.ov && res_s2.acc == '0 && res_s2.b == '0 && !res_s2.c)
		else $error("divide by zero result wrong");

	// parity register follows the accumulator it was taken with
	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> par_s3 == ^res_s3.acc)
		else $error("parity out of step with accumulator");

	// a divide by a nonzero divisor leaves the remainder below it, overflow clear
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		ready_s2 && v_s1 && is_div_s1 && divisor_s1 != '0
		|=> res_s2.b < $past(divisor_s1) && !res_s2.ov)
		else $error("divide remainder not below divisor");
`endif

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stand-alone regression for the pipelined 8-bit ALU with status flags.
// A short table of hand-picked operations is followed by random operations.
// Each result beat is checked against a table outcome or a local ALU model.
// Both ends stall at random, with one long output stall and full drains.
// ----------------------------------------------------------------------------
module tb;
	import ealu_pkg::*;

	// clock, reset and run bounds
	localparam int unsigned HalfPeriod     = 6;
	localparam int unsigned ResetCycles    = 7;
	localparam int unsigned RandomItems    = 2000;
	localparam int unsigned DrainCycles    = 16;
	localparam int unsigned CycleLimit     = 800000;
	localparam int unsigned MaxReports     = 10;
	// one long output stall once this many beats went in
	localparam int unsigned LongHoldAfter  = 800;
	localparam int unsigned LongHoldCycles = 250;
	// sender waits for an empty pipe once at this beat of the random part
	localparam int unsigned DrainPauseAt   = 1500;

	// command codes the ALU leaves undecoded
	localparam logic [CmdW-1:0] CMD_SPARE_LO = 5'd20;
	localparam logic [CmdW-1:0] CMD_SPARE_HI = 5'd31;

	// one request beat
	typedef struct packed {
		logic [CmdW-1:0]  command;
		logic [DataW-1:0] acc;
		logic [DataW-1:0] operand;
		logic [DataW-1:0] b;
		logic             c;
		logic             ac;
		logic             ov;
	} alu_request_t;

	// one response beat
	typedef struct packed {
		logic [DataW-1:0] acc;
		logic [DataW-1:0] b;
		logic             c;
		logic             ac;
		logic             ov;
		logic             p;
	} alu_outcome_t;

	// hand-picked row: fixed outcome where it is obvious, else the model decides
	typedef struct packed {
		alu_request_t op;
		logic         fixed;
		alu_outcome_t want;
	} alu_case_t;

	localparam int unsigned CaseCount = 27;

	// fields: command, acc, operand, b, carry, aux, ovf
	localparam alu_case_t ALU_CASES [CaseCount] = '{
		// add wraps to zero, carry and aux out
		'{'{CMD_ADD,  8'hFF, 8'h01, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0}},
		// signed overflow on positive + positive
		'{'{CMD_ADD,  8'h7F, 8'h01, 8'h5A, 1'b0, 1'b0, 1'b1}, 1'b1,
			'{8'h80, 8'h5A, 1'b0, 1'b1, 1'b1, 1'b1}},
		// largest add with carry in
		'{'{CMD_ADDC, 8'hFF, 8'hFF, 8'hAA, 1'b1, 1'b0, 1'b0}, 1'b1,
			'{8'hFF, 8'hAA, 1'b1, 1'b1, 1'b0, 1'b0}},
		// borrow out of zero
		'{'{CMD_SUBB, 8'h00, 8'h01, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{8'hFF, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0}},
		// borrow in flips sign: overflow
		'{'{CMD_SUBB, 8'h80, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0}, 1'b1,
			'{8'h7F, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b1}},
		'{'{CMD_INC,  8'hFF, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
		'{'{CMD_DEC,  8'h00, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
		'{'{CMD_OR,   8'hA5, 8'h5A, 8'h00, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
		'{'{CMD_AND,  8'hF0, 8'h3C, 8'h00, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
		'{'{CMD_XOR,  8'hFF, 8'hAA, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{CMD_RR,   8'h01, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{CMD_RRC,  8'h01, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{CMD_RL,   8'h80, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{CMD_RLC,  8'h80, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
		'{'{CMD_SWAP, 8'hA5, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
		// decimal adjust: low nibble out of range, then the adjusted high nibble too
		'{'{CMD_DA,   8'h9A, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
		// decimal adjust keeps a carry already set
		'{'{CMD_DA,   8'h12, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
		// decimal adjust driven by aux alone
		'{'{CMD_DA,   8'h19, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
		// low adjust itself carries out of bit 7
		'{'{CMD_DA,   8'hFA, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
		// largest product
		'{'{CMD_MUL,  8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0}, 1'b1,
			'{8'h01, 8'hFE, 1'b0, 1'b0, 1'b1, 1'b1}},
		// divide by zero
		'{'{CMD_DIV,  8'hFF, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0}, 1'b1,
			'{8'h00, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0}},
		'{'{CMD_DIV,  8'hFF, 8'h00, 8'h01, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
		'{'{CMD_CPL,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{CMD_CLR,  8'hFF, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
		'{'{CMD_CMP,  8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{CMD_MOV,  8'h00, 8'hFF, 8'h33, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
		// undecoded code passes everything through
		'{'{CMD_SPARE_HI, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0}}
	};

	logic clk;
	logic arst_n;

	ealu_req_if req_ch ();
	ealu_rsp_if rsp_ch ();

	eight_bit_alu_with_psw_flags_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// outcomes of accepted request beats, oldest first
	alu_outcome_t pending_outcomes [$];
	int unsigned  beats_sent;
	int unsigned  mismatch_count;
	int unsigned  cycle_count;

	initial begin
		clk = 1'b0;
		forever #(HalfPeriod) clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// ALU model: what one request beat must produce
	// ------------------------------------------------------------------------
	function automatic alu_outcome_t predict_alu(input alu_request_t op);
		alu_outcome_t res;
		logic [8:0]   wide;
		logic [8:0]   rhs;
		logic [4:0]   nib;
		logic [15:0]  prod;
		logic         cin;
		// untouched fields pass through
		res.acc = op.acc;
		res.b   = op.b;
		res.c   = op.c;
		res.ac  = op.ac;
		res.ov  = op.ov;
		case (op.command)
			CMD_ADD, CMD_ADDC: begin
				cin     = (op.command == CMD_ADDC) ? op.c : 1'b0;
				wide    = {1'b0, op.acc} + {1'b0, op.operand} + {8'd0, cin};
				nib     = {1'b0, op.acc[3:0]} + {1'b0, op.operand[3:0]} + {4'd0, cin};
				res.acc = wide[7:0];
				res.c   = wide[8];
				res.ac  = nib[4];
				res.ov  = ~(op.acc[7] ^ op.operand[7]) & (op.acc[7] ^ res.acc[7]);
			end
			CMD_SUBB: begin
				rhs     = {1'b0, op.operand} + {8'd0, op.c};
				wide    = {1'b0, op.acc} - rhs;
				res.acc = wide[7:0];
				res.ac  = {1'b0, op.acc[3:0]} < ({1'b0, op.operand[3:0]} + {4'd0, op.c});
				res.c   = {1'b0, op.acc} < rhs;
				res.ov  = (op.acc[7] ^ op.operand[7]) & (op.acc[7] ^ res.acc[7]);
			end
			CMD_INC:  res.acc = op.acc + 8'd1;
			CMD_DEC:  res.acc = op.acc - 8'd1;
			CMD_OR:   res.acc = op.acc | op.operand;
			CMD_AND:  res.acc = op.acc & op.operand;
			CMD_XOR:  res.acc = op.acc ^ op.operand;
			CMD_RR:   res.acc = {op.acc[0], op.acc[7:1]};
			CMD_RRC: begin
				res.acc = {op.c, op.acc[7:1]};
				res.c   = op.acc[0];
			end
			CMD_RL:   res.acc = {op.acc[6:0], op.acc[7]};
			CMD_RLC: begin
				res.acc = {op.acc[6:0], op.c};
				res.c   = op.acc[7];
			end
			CMD_SWAP: res.acc = {op.acc[3:0], op.acc[7:4]};
			CMD_DA: begin
				// carry may be set by either step, never cleared
				wide = {1'b0, op.acc};
				if (wide[3:0] > BcdDigitMax || op.ac) begin
					wide = wide + {1'b0, DaLoAdj};
					if (wide[8])
						res.c = 1'b1;
					wide[8] = 1'b0;
				end
				if (wide[7:4] > BcdDigitMax || res.c) begin
					wide  = {1'b0, wide[7:0] + DaHiAdj};
					res.c = 1'b1;
				end
				res.acc = wide[7:0];
			end
			CMD_MUL: begin
				prod    = {8'd0, op.acc} * {8'd0, op.b};
				res.acc = prod[7:0];
				res.b   = prod[15:8];
				res.c   = 1'b0;
				res.ov  = |prod[15:8];
			end
			CMD_DIV: begin
				if (op.b == '0) begin
					res.acc = '0;
					res.b   = '0;
					res.ov  = 1'b1;
				end else begin
					res.acc = op.acc / op.b;
					res.b   = op.acc % op.b;
					res.ov  = 1'b0;
				end
				res.c = 1'b0;
			end
			CMD_CPL:  res.acc = ~op.acc;
			CMD_CLR:  res.acc = '0;
			CMD_CMP:  res.c   = op.acc < op.operand;
			CMD_MOV:  res.acc = op.operand;
			default: begin
			end
		endcase
		res.p = ^res.acc;
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// random stimulus helpers
	// ------------------------------------------------------------------------

	// idle length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// bytes lean toward the two extremes
	function automatic logic [DataW-1:0] pick_byte();
		int unsigned roll;
		roll = $urandom_range(0, 7);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return DataW'($urandom);
	endfunction

	function automatic alu_request_t random_request();
		alu_request_t op;
		// undecoded codes only now and then
		if ($urandom_range(0, 9) == 0)
			op.command = CmdW'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		else
			op.command = CmdW'($urandom_range(CMD_ADD, CMD_MOV));
		op.acc     = pick_byte();
		op.operand = pick_byte();
		op.b       = pick_byte();
		// divisor of zero a bit more often than chance
		if (op.command == CMD_DIV && $urandom_range(0, 5) == 0)
			op.b = '0;
		op.c  = 1'($urandom);
		op.ac = 1'($urandom);
		op.ov = 1'($urandom);
		return op;
	endfunction

	// ------------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------------

	// offer one beat, wait for it to be taken, then log its outcome
	task automatic send_beat(input alu_request_t op, input logic fixed,
			input alu_outcome_t want);
		req_ch.valid    <= 1'b1;
		req_ch.command  <= op.command;
		req_ch.acc_in   <= op.acc;
		req_ch.operand  <= op.operand;
		req_ch.b_in     <= op.b;
		req_ch.carry_in <= op.c;
		req_ch.aux_in   <= op.ac;
		req_ch.ovf_in   <= op.ov;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		pending_outcomes.push_back(fixed ? want : predict_alu(op));
		beats_sent++;
	endtask

	// drop valid for a while; called only right after a beat was taken
	task automatic sender_idle(input int unsigned cycles);
		if (cycles > 0) begin
			req_ch.valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// stop offering until every outstanding result is back
	task automatic sender_drain();
		req_ch.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	initial begin : stimulus
		bit no_idle;
		no_idle = 1'b0;
		beats_sent = 0;

		// every input known from time zero, with reset asserted
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.command   <= CMD_ADD;
		req_ch.acc_in    <= '0;
		req_ch.operand   <= '0;
		req_ch.b_in      <= '0;
		req_ch.carry_in  <= 1'b0;
		req_ch.aux_in    <= 1'b0;
		req_ch.ovf_in    <= 1'b0;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hand-picked cases
		for (int i = 0; i < CaseCount; i++) begin
			send_beat(ALU_CASES[i].op, ALU_CASES[i].fixed, ALU_CASES[i].want);
			sender_idle(pick_gap());
		end
		sender_drain();

		// random operations; stretches without idling come and go
		for (int i = 0; i < RandomItems; i++) begin
			send_beat(random_request(), 1'b0, '0);
			if ($urandom_range(0, 99) == 0)
				no_idle = ~no_idle;
			if (i == DrainPauseAt)
				sender_drain();
			else if (!no_idle)
				sender_idle(pick_gap());
		end
		req_ch.valid <= 1'b0;

		// wait for the pipe to empty, then for any stray beats
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------------
	// response side: random back-pressure, one long hold-off
	// ------------------------------------------------------------------------
	initial begin : receiver
		int unsigned hold;
		bit          no_idle;
		bit          long_hold_done;
		hold           = 0;
		no_idle        = 1'b0;
		long_hold_done = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!long_hold_done && beats_sent >= LongHoldAfter) begin
				// sender keeps going, so the pipe fills and req.ready drops
				hold           = LongHoldCycles;
				long_hold_done = 1'b1;
			end else if (hold == 0) begin
				if ($urandom_range(0, 199) == 0)
					no_idle = ~no_idle;
				hold = no_idle ? 0 : pick_gap();
			end
			if (hold > 0) begin
				rsp_ch.ready <= 1'b0;
				hold--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// result check: each taken beat against the oldest outcome waiting
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : response_check
		alu_outcome_t got;
		alu_outcome_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got.acc = rsp_ch.acc_out;
			got.b   = rsp_ch.b_out;
			got.c   = rsp_ch.carry_out;
			got.ac  = rsp_ch.aux_out;
			got.ov  = rsp_ch.ovf_out;
			got.p   = rsp_ch.parity_out;
			if (pending_outcomes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MaxReports)
					$display("%0t: unexpected result beat acc=%h b=%h c=%b ac=%b ov=%b p=%b",
						$realtime, got.acc, got.b, got.c, got.ac, got.ov, got.p);
			end else begin
				want = pending_outcomes.pop_front();
				if (got.acc !== want.acc || got.b !== want.b || got.c !== want.c ||
						got.ac !== want.ac || got.ov !== want.ov || got.p !== want.p) begin
					mismatch_count++;
					if (mismatch_count <= MaxReports) begin
						$display("%0t: mismatch exp acc=%h b=%h c=%b ac=%b ov=%b p=%b",
							$realtime, want.acc, want.b, want.c, want.ac, want.ov, want.p);
						$display("%0t:          got acc=%h b=%h c=%b ac=%b ov=%b p=%b",
							$realtime, got.acc, got.b, got.c, got.ac, got.ov, got.p);
					end
				end
			end
		end
	end

	// hard stop if the pipe hangs
	initial begin
		mismatch_count = 0;
		cycle_count    = 0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("%0t: timeout, %0d results outstanding", $realtime,
				pending_outcomes.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule
